>>> rtl/core/assert_macros.svh
// assertion macros for the cipher unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`endif

>>> rtl/core/aes_cfb_pkg.sv
// shared types, tables and round functions of the aes cfb unit
package aes_cfb_pkg;
    localparam int BLOCK_W = 128;
    localparam logic [4:0] FULL_COUNT = 5'd16;
    localparam logic [3:0] ROUNDS_SHORT = 4'd10;
    localparam logic [3:0] ROUNDS_LONG = 4'd14;
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_RESTART = 1'b1;
    localparam logic DIR_ENCRYPT = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_KEYEXP = 5'b00010,
        ST_ROUND  = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_OUTPUT = 5'b10000
    } state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
        return v[127 - 8 * i -: 8];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int i = 0; i < 16; i++) begin
            t[127 - 8 * i -: 8] = sbox(get_byte(s, (i % 4) + 4 * (((i / 4) + (i % 4)) % 4)));
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = get_byte(t, 4 * c);
                a1 = get_byte(t, 4 * c + 1);
                a2 = get_byte(t, 4 * c + 2);
                a3 = get_byte(t, 4 * c + 3);
                al = a0 ^ a1 ^ a2 ^ a3;
                t[127 - 32 * c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                         a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
            end
        end
        return t;
    endfunction
endpackage

>>> rtl/core/aes_cfb_ram.sv
// generic ram with one write port and one registered read port
module aes_cfb_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/aes_cfb_stream_cipher_unit.sv
// top level of the aes cfb128 stream cipher unit
// A request is accepted and then runs alone. A restart expands the key one 128-bit round
// key (four schedule words) per cycle into the round key ram, 11 or 15 round keys, then
// goes to the result. A data block first loads round key 0 from the registered ram read,
// then runs one aes round per cycle through the shared round unit, 10 or 14 rounds;
// refused blocks go straight to the result. The result sits in an output register until
// taken, and the next request is accepted in the cycle after it leaves.
`include "assert_macros.svh"
module aes_cfb_stream_cipher_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // data_high, data_low, byte_count, zero fill
    input  logic [135:0] s_tdata,
    // command
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_high, result_low, result_count, zero fill
    output logic [135:0] m_tdata,
    // status
    output logic         m_tuser
);
    localparam logic [2:0] IDX_K0 = 3'd0, IDX_K1 = 3'd1, IDX_K2 = 3'd2, IDX_K3 = 3'd3;
    localparam logic [2:0] IDX_IVH = 3'd4, IDX_IVL = 3'd5, IDX_LONG = 3'd6, IDX_DIR = 3'd7;

    logic [63:0] key_reg [4];
    logic [63:0] ivh_reg, ivl_reg;
    logic long_reg, dir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            ivh_reg <= '0;
            ivl_reg <= '0;
            long_reg <= 1'b0;
            dir_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                IDX_K0:   key_reg[0] <= cfg_wdata;
                IDX_K1:   key_reg[1] <= cfg_wdata;
                IDX_K2:   key_reg[2] <= cfg_wdata;
                IDX_K3:   key_reg[3] <= cfg_wdata;
                IDX_IVH:  ivh_reg <= cfg_wdata;
                IDX_IVL:  ivl_reg <= cfg_wdata;
                IDX_LONG: long_reg <= cfg_wdata[0];
                IDX_DIR:  dir_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    aes_cfb_pkg::state_t state_reg;
    logic [127:0] fb_reg, st_reg, din_reg, res_reg;
    logic [255:0] ks_reg;
    logic [7:0] rcon_reg;
    logic [3:0] cnt_reg, nr_reg;
    logic [4:0] n_reg, rcnt_reg;
    logic fin_reg, stat_reg, long_run_reg;

    logic ram_we;
    logic [3:0] ram_waddr, ram_raddr;
    logic [127:0] ram_wdata, rk;

    aes_cfb_ram #(.WIDTH(128), .DEPTH(15)) u_rk_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(rk)
    );

    logic [127:0] round_out;
    assign round_out = aes_cfb_pkg::enc_round(st_reg, cnt_reg == nr_reg);

    // key schedule step: round key cnt from the 256-bit window
    logic [31:0] w0, w1, w2, w3, tw, hw;
    logic [127:0] next_half;
    logic [4:0] n_sat;
    logic [127:0] mask, dout;

    always_comb begin
        tw = aes_cfb_pkg::sub_word(long_run_reg ? ks_reg[31:0] : ks_reg[159:128]);
        tw = {tw[23:0], tw[31:24]} ^ {rcon_reg, 24'h0};
        hw = aes_cfb_pkg::sub_word(ks_reg[31:0]);
        // 128-bit key: words in ks_reg[255:128]; 256-bit: odd steps use sub only
        if (!long_run_reg || !cnt_reg[0]) begin
            w0 = (long_run_reg ? ks_reg[255:224] : ks_reg[255:224]) ^ tw;
        end else begin
            w0 = ks_reg[255:224] ^ hw;
        end
        w1 = ks_reg[223:192] ^ w0;
        w2 = ks_reg[191:160] ^ w1;
        w3 = ks_reg[159:128] ^ w2;
        next_half = {w0, w1, w2, w3};
        n_sat = (s_tdata[132:128] > aes_cfb_pkg::FULL_COUNT) ? aes_cfb_pkg::FULL_COUNT
                                                             : s_tdata[132:128];
        for (int i = 0; i < 16; i++) begin
            mask[127 - 8 * i -: 8] = (5'(i) < n_reg) ? 8'hff : 8'h00;
        end
        dout = (round_out ^ rk ^ din_reg) & mask;
    end

    logic s_acc, m_acc;
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign s_tready = (state_reg == aes_cfb_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == aes_cfb_pkg::ST_OUTPUT);
    assign m_tdata = {3'd0, rcnt_reg, res_reg[63:0], res_reg[127:64]};
    assign m_tuser = stat_reg;

    always_comb begin
        ram_we = (state_reg == aes_cfb_pkg::ST_KEYEXP);
        ram_waddr = cnt_reg;
        ram_wdata = long_run_reg ? ks_reg[255:128] : ks_reg[255:128];
        ram_raddr = (state_reg == aes_cfb_pkg::ST_FINISH ||
                     (state_reg == aes_cfb_pkg::ST_ROUND && cnt_reg != nr_reg))
                    ? cnt_reg + 4'd1 : 4'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aes_cfb_pkg::ST_IDLE;
            fin_reg <= 1'b1;
            fb_reg <= '0;
            nr_reg <= aes_cfb_pkg::ROUNDS_SHORT;
            cnt_reg <= '0;
        end else begin
            case (state_reg)
                aes_cfb_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        din_reg <= {s_tdata[63:0], s_tdata[127:64]};
                        n_reg <= n_sat;
                        cnt_reg <= '0;
                        res_reg <= '0;
                        rcnt_reg <= '0;
                        stat_reg <= 1'b0;
                        if (s_tuser == aes_cfb_pkg::CMD_RESTART) begin
                            ks_reg <= {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
                            long_run_reg <= long_reg;
                            rcon_reg <= 8'h01;
                            nr_reg <= long_reg ? aes_cfb_pkg::ROUNDS_LONG
                                               : aes_cfb_pkg::ROUNDS_SHORT;
                            fb_reg <= {ivh_reg, ivl_reg};
                            fin_reg <= 1'b0;
                            state_reg <= aes_cfb_pkg::ST_KEYEXP;
                        end else if (fin_reg) begin
                            stat_reg <= 1'b1;
                            state_reg <= aes_cfb_pkg::ST_OUTPUT;
                        end else begin
                            state_reg <= aes_cfb_pkg::ST_FINISH;
                        end
                    end
                end
                aes_cfb_pkg::ST_KEYEXP: begin
                    // write ks_reg[255:128] as round key cnt, then slide the window
                    if (long_run_reg) begin
                        ks_reg <= {ks_reg[127:0], next_half};
                        if (cnt_reg[0]) rcon_reg <= aes_cfb_pkg::xtime(rcon_reg);
                    end else begin
                        ks_reg <= {next_half, ks_reg[127:0]};
                        rcon_reg <= aes_cfb_pkg::xtime(rcon_reg);
                    end
                    if (cnt_reg == nr_reg) begin
                        state_reg <= aes_cfb_pkg::ST_OUTPUT;
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                end
                aes_cfb_pkg::ST_FINISH: begin
                    // round key 0 is on the ram output now
                    st_reg <= fb_reg ^ rk;
                    cnt_reg <= 4'd1;
                    state_reg <= aes_cfb_pkg::ST_ROUND;
                end
                aes_cfb_pkg::ST_ROUND: begin
                    if (cnt_reg == nr_reg) begin
                        // last round without mix columns; rk is the final key
                        rcnt_reg <= n_reg;
                        res_reg <= dout;
                        if (n_reg != aes_cfb_pkg::FULL_COUNT) begin
                            fin_reg <= 1'b1;
                        end else begin
                            fb_reg <= (dir_reg == aes_cfb_pkg::DIR_ENCRYPT) ? dout : din_reg;
                        end
                        state_reg <= aes_cfb_pkg::ST_OUTPUT;
                    end else begin
                        st_reg <= round_out ^ rk;
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                aes_cfb_pkg::ST_OUTPUT: begin
                    if (m_acc) state_reg <= aes_cfb_pkg::ST_IDLE;
                end
                default: state_reg <= aes_cfb_pkg::ST_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_onehot, $onehot(state_reg), "state not one-hot")
    `ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(res_reg), "result lost")
    `ASSERT_IMPL(a_rounds, !(state_reg == aes_cfb_pkg::ST_ROUND) || cnt_reg <= nr_reg,
        "round count overrun")
endmodule

>>> dv/cfb_checker.sv
// checker for the aes cfb unit: watches both channels and the register port, predicts, compares
`timescale 1ns / 100ps
module cfb_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic         m_tuser,
    output int           errors,
    output int           pending,
    output int           results_seen
);
    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_IV_HI = 3'd4;
    localparam logic [2:0] REG_IV_LO = 3'd5;
    localparam logic [2:0] REG_LONG_KEY = 3'd6;
    localparam logic [2:0] REG_DIRECTION = 3'd7;

    typedef struct packed {
        logic [127:0] blk;
        logic [4:0]   cnt;
        logic         status;
    } cipher_out_t;

    cipher_out_t  cipher_out_q[$];
    logic [7:0]   sub_tab[256];
    logic [63:0]  key_reg[4];
    logic [127:0] iv_reg;
    logic         long_key_reg;
    logic         dir_reg;
    logic [127:0] feedback;
    logic         finished;
    logic [127:0] round_key[15];
    int           nrounds;

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p = p ^ a;
            a = gf_double(a);
        end
        return p;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    // s-box built from the field inverse and the affine map
    initial begin
        logic [7:0] inv;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++) begin
                if (gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
            end
            sub_tab[a] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                         ^ 8'h63;
        end
    end

    task automatic expand_keys();
        logic [31:0]  w[60];
        logic [255:0] kb;
        logic [31:0]  t;
        logic [7:0]   rc;
        int           nk;
        int           total;
        kb = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
        nk = long_key_reg ? 8 : 4;
        nrounds = long_key_reg ? 14 : 10;
        total = 4 * (nrounds + 1);
        rc = 8'h01;
        for (int i = 0; i < nk; i++) w[i] = kb[255 - 32 * i -: 32];
        for (int i = nk; i < total; i++) begin
            t = w[i - 1];
            if (i % nk == 0) begin
                t = {sub_tab[t[23:16]] ^ rc, sub_tab[t[15:8]], sub_tab[t[7:0]],
                     sub_tab[t[31:24]]};
                rc = gf_double(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = {sub_tab[t[31:24]], sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]};
            end
            w[i] = w[i - nk] ^ t;
        end
        for (int r = 0; r < 15; r++) round_key[r] = '0;
        for (int i = 0; i < total; i++) round_key[i / 4][127 - 32 * (i % 4) -: 32] = w[i];
    endtask

    function automatic logic [127:0] keystream_of(input logic [127:0] blk_in);
        logic [127:0] s;
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, al;
        int           row, col;
        s = blk_in ^ round_key[0];
        for (int r = 1; r <= nrounds; r++) begin
            for (int i = 0; i < 16; i++) begin
                row = i % 4;
                col = i / 4;
                t[127 - 8 * i -: 8] = sub_tab[s[127 - 8 * (row + 4 * ((col + row) % 4)) -: 8]];
            end
            if (r != nrounds) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[127 - 32 * c -: 8];
                    a1 = t[119 - 32 * c -: 8];
                    a2 = t[111 - 32 * c -: 8];
                    a3 = t[103 - 32 * c -: 8];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[127 - 32 * c -: 32] = {a0 ^ al ^ gf_double(a0 ^ a1),
                                             a1 ^ al ^ gf_double(a1 ^ a2),
                                             a2 ^ al ^ gf_double(a2 ^ a3),
                                             a3 ^ al ^ gf_double(a3 ^ a0)};
                end
            end
            s = t ^ round_key[r];
        end
        return s;
    endfunction

    always @(posedge aclk) begin
        cipher_out_t  want;
        logic [127:0] din;
        logic [127:0] ks;
        logic [127:0] got_blk;
        logic [4:0]   n;
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) key_reg[k] = '0;
            iv_reg = '0;
            long_key_reg = 1'b0;
            dir_reg = aes_cfb_pkg::DIR_ENCRYPT;
            feedback = '0;
            finished = 1'b1;
            for (int r = 0; r < 15; r++) round_key[r] = '0;
            nrounds = 10;
            cipher_out_q.delete();
            errors = 0;
            results_seen = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[cfg_index[1:0]] = cfg_wdata;
                    REG_IV_HI: iv_reg[127:64] = cfg_wdata;
                    REG_IV_LO: iv_reg[63:0] = cfg_wdata;
                    REG_LONG_KEY: long_key_reg = cfg_wdata[0];
                    REG_DIRECTION: dir_reg = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = '0;
                if (s_tuser == aes_cfb_pkg::CMD_RESTART) begin
                    expand_keys();
                    feedback = iv_reg;
                    finished = 1'b0;
                end else if (finished) begin
                    want.status = 1'b1;
                end else begin
                    din = {s_tdata[63:0], s_tdata[127:64]};
                    n = (s_tdata[132:128] > aes_cfb_pkg::FULL_COUNT) ? aes_cfb_pkg::FULL_COUNT
                                                                     : s_tdata[132:128];
                    ks = keystream_of(feedback);
                    for (int i = 0; i < 16; i++) begin
                        if (i < n) want.blk[127 - 8 * i -: 8] = din[127 - 8 * i -: 8]
                                                             ^ ks[127 - 8 * i -: 8];
                    end
                    want.cnt = n;
                    if (n < aes_cfb_pkg::FULL_COUNT) finished = 1'b1;
                    else feedback = (dir_reg != aes_cfb_pkg::DIR_ENCRYPT) ? din : want.blk;
                end
                cipher_out_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got_blk = {m_tdata[63:0], m_tdata[127:64]};
                if (cipher_out_q.size() == 0) begin
                    errors++;
                    $display("%0t: result expected none actual blk=%h cnt=%0d status=%0b",
                             $time, got_blk, m_tdata[132:128], m_tuser);
                end else begin
                    want = cipher_out_q.pop_front();
                    if (got_blk !== want.blk) begin
                        errors++;
                        $display("%0t: result block expected %h actual %h", $time,
                                 want.blk, got_blk);
                    end
                    if (m_tdata[132:128] !== want.cnt) begin
                        errors++;
                        $display("%0t: result count expected %0d actual %0d", $time,
                                 want.cnt, m_tdata[132:128]);
                    end
                    if (m_tuser !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0b actual %0b", $time,
                                 want.status, m_tuser);
                    end
                end
            end
        end
        pending = cipher_out_q.size();
    end
endmodule

>>> dv/tb.sv
// testbench top for the aes cfb unit: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_IV_HI = 3'd4;
    localparam logic [2:0] REG_IV_LO = 3'd5;
    localparam logic [2:0] REG_LONG_KEY = 3'd6;
    localparam logic [2:0] REG_DIRECTION = 3'd7;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tuser;
    int           errors;
    int           pending;
    int           results_seen;
    int           cycles = 0;
    int           sent;
    int           restarts;
    int           phases;
    logic         quiet;

    aes_cfb_stream_cipher_unit u_top (.*);

    cfb_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send(input logic cmd, input logic [63:0] hi, input logic [63:0] lo,
                        input logic [4:0] cnt);
        while (!quiet && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {3'd0, cnt, lo, hi};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent++;
        if (cmd == aes_cfb_pkg::CMD_RESTART) restarts++;
    endtask

    task automatic data(input logic [4:0] cnt);
        send(aes_cfb_pkg::CMD_DATA, rand_word(), rand_word(), cnt);
    endtask

    task automatic restart();
        send(aes_cfb_pkg::CMD_RESTART, {$urandom, $urandom}, {$urandom, $urandom},
             5'($urandom_range(31)));
    endtask

    // wait for all results, then let the block settle before a register write
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // write enable stays high until the caller drops it
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic setup(input logic long_key, input logic dir, input int key_kind);
        for (int k = 0; k < 4; k++) begin
            write_reg(REG_KEY0 + k[2:0], key_kind == 0 ? 64'd0 :
                      key_kind == 1 ? '1 : {$urandom, $urandom});
        end
        write_reg(REG_IV_HI, rand_word());
        write_reg(REG_IV_LO, rand_word());
        write_reg(REG_LONG_KEY, {63'd0, long_key});
        write_reg(REG_DIRECTION, {63'd0, dir});
        cfg_we <= 1'b0;
    endtask

    initial begin
        int n;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = aes_cfb_pkg::CMD_DATA;
        sent = 0;
        restarts = 0;
        phases = 0;
        quiet = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: refused before restart, extremes, short and empty blocks, saturation
        send(aes_cfb_pkg::CMD_DATA, '1, '1, 5'd16);
        restart();
        send(aes_cfb_pkg::CMD_DATA, '0, '0, 5'd16);
        send(aes_cfb_pkg::CMD_DATA, '1, '1, 5'd16);
        send(aes_cfb_pkg::CMD_DATA, '1, '1, 5'd31);
        send(aes_cfb_pkg::CMD_DATA, '1, '1, 5'd5);
        send(aes_cfb_pkg::CMD_DATA, '1, '1, 5'd16);
        drain();
        setup(1'b1, 1'b0, 1);
        restart();
        send(aes_cfb_pkg::CMD_DATA, '1, '0, 5'd17);
        send(aes_cfb_pkg::CMD_DATA, '0, '1, 5'd0);
        send(aes_cfb_pkg::CMD_DATA, '0, '1, 5'd16);
        drain();
        setup(1'b1, 1'b1, 0);
        restart();
        data(5'd16);
        data(5'd16);
        drain();
        // key length and iv change without restart: only direction takes effect
        write_reg(REG_LONG_KEY, 64'd0);
        write_reg(REG_IV_HI, '1);
        write_reg(REG_DIRECTION, {63'd0, aes_cfb_pkg::DIR_ENCRYPT});
        cfg_we <= 1'b0;
        data(5'd16);
        data(5'd15);
        drain();

        while (sent < 2000) begin
            phases++;
            quiet = (phases >= 40 && phases < 55);
            setup(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(3));
            restart();
            n = $urandom_range(30);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(19))
                    0: data(5'($urandom_range(31)));
                    1: restart();
                    default: data(5'd16);
                endcase
            end
            case ($urandom_range(3))
                0: data(5'($urandom_range(15)));
                1: begin
                    data(5'($urandom_range(15)));
                    data(5'($urandom_range(31)));
                end
                default: ;
            endcase
            drain();
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        $display("covered %0d requests in %0d phases, %0d restarts, %0d results checked",
                 sent, phases, restarts, results_seen);
        $display("both key lengths and directions, short, empty and refused blocks");
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
